/* rtl/core/lfo_am_pkg.sv */
`default_nettype none

package lfo_am_pkg;

  localparam int TABLE_BITS    = 11;
  localparam int SAMPLE_BITS   = 24;
  localparam int PHASE_BITS    = 32;
  localparam int SINE_BITS     = 16;
  localparam int DEPTH_BITS    = 16;
  localparam int CFG_DATA_BITS = 32;

  localparam int TABLE_SIZE   = 1 << TABLE_BITS;
  localparam int FRAC_BITS    = PHASE_BITS - TABLE_BITS;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QSIZE        = 1 << QUARTER_BITS;

  // Reciprocal of five for a 31-bit dividend, exact after a shift of 34
  localparam logic [PHASE_BITS-1:0] RECIP5     = 32'hCCCC_CCCD;
  localparam int                    QUOT_SHIFT = 34;
  localparam int                    QPROD_BITS = 2 * PHASE_BITS - 1;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  localparam logic [PHASE_BITS-1:0] MONO_STEP_RESET   = 32'd262144;
  localparam logic [PHASE_BITS-1:0] STEREO_STEP_RESET = 32'd589824;
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET       = 16'd58982;

  typedef enum logic [1:0] {
    REG_STEREO_MODE,
    REG_MONO_STEP,
    REG_STEREO_STEP,
    REG_DEPTH
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          out_last;
  } out_item_t;

  typedef logic [SINE_BITS-1:0] qtab_t [0:QSIZE];

  // 32767 * sin(k * pi/2 / QSIZE) by a Q30 Taylor series
  function automatic logic [SINE_BITS-1:0] quarter_sine(input int k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (64'(k) * HALFPI_Q30 + (64'd1 << (QUARTER_BITS - 1))) >> QUARTER_BITS;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return SINE_BITS'(v);
  endfunction

  function automatic qtab_t build_quarter_tab();
    qtab_t tab;
    for (int i = 0; i <= QSIZE; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

  localparam qtab_t QUARTER_TAB = build_quarter_tab();

  // Full-period entry from the quarter wave by symmetry
  function automatic logic [SINE_BITS-1:0] sine_entry(input logic [TABLE_BITS-1:0] idx);
    logic [1:0]              quad;
    logic [QUARTER_BITS:0]   k;
    logic [QUARTER_BITS:0]   qi;
    logic [SINE_BITS-1:0]    v;
    quad = idx[TABLE_BITS-1 -: 2];
    k    = {1'b0, idx[QUARTER_BITS-1:0]};
    qi   = quad[0] ? ((QUARTER_BITS + 1)'(QSIZE) - k) : k;
    v    = QUARTER_TAB[qi];
    return quad[1] ? (~v + SINE_BITS'(1)) : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lfo_am_ram.sv */
`default_nettype none

module lfo_am_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/sine_lfo_amplitude_modulator_unit.sv */
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data  (left, right, block_last)
// out       out_valid / out_ready  out_data (left, right, last)
// cfg       cfg_we                 cfg_index, cfg_data
//
// After reset a fill sweep writes the 2048-entry sine RAM, with in_ready low throughout.
// In a transaction each channel (left only in mono, then right in stereo) needs two reads
// of the sine RAM's single read port and then five steps through the shared interpolation,
// gain and sample multipliers. The result sits in an output register, so a stalled
// output holds only that register; the next transaction is taken meanwhile, and the
// sequencer waits only when a second result is ready before the first has gone.

module sine_lfo_amplitude_modulator_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire lfo_am_pkg::in_item_t                   in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output lfo_am_pkg::out_item_t                       out_data,
  input  wire logic                                   cfg_we,
  input  wire lfo_am_pkg::cfg_reg_t                   cfg_index,
  input  wire logic [lfo_am_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import lfo_am_pkg::*;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_DIFF,
    S_INTERP,
    S_GAIN,
    S_SMUL,
    S_ROUND,
    S_OUT
  } state_t;

  state_t state;

  logic                    stereo_mode;
  logic [PHASE_BITS-1:0]   mono_step;
  logic [PHASE_BITS-1:0]   stereo_step;
  logic [DEPTH_BITS-1:0]   depth;

  logic [PHASE_BITS-1:0]   phase;
  logic [PHASE_BITS-1:0]   ch_phase;
  logic [PHASE_BITS-1:0]   right_phase;
  logic [QPROD_BITS-1:0]   quot_prod;
  logic                    is_right;
  in_item_t                item;

  logic [TABLE_BITS-1:0]   fill_addr;
  logic                    ram_we;
  logic [TABLE_BITS-1:0]   ram_raddr;
  logic [SINE_BITS-1:0]    ram_rdata;
  logic [TABLE_BITS-1:0]   tab_index;

  logic signed [SINE_BITS-1:0]  s0;
  logic                         d_neg;
  logic [SINE_BITS:0]           d_mag;
  logic [SINE_BITS:0]           interp_t;
  logic [PHASE_BITS-1:0]        gain_p;
  logic [SAMPLE_BITS+PHASE_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0]       smag;
  logic                         sneg;
  logic [SAMPLE_BITS-1:0]       left_res;
  logic [SAMPLE_BITS-1:0]       right_res;

  logic signed [SAMPLE_BITS-1:0]      cur_sample;
  logic signed [SINE_BITS:0]          diff;
  logic [SINE_BITS+FRAC_BITS:0]       interp_prod;
  logic signed [SINE_BITS+1:0]        s_val;
  logic [SINE_BITS-1:0]               u_val;
  logic [SAMPLE_BITS+PHASE_BITS:0]    acc;
  logic [SAMPLE_BITS-1:0]             r_mag;
  logic [SAMPLE_BITS-1:0]             res;
  logic [QPROD_BITS-QUOT_SHIFT-1:0]   quot;

  assign in_ready  = (state == S_IDLE);
  assign ram_we    = (state == S_FILL);
  assign tab_index = ch_phase[PHASE_BITS-1 -: TABLE_BITS];

  always_comb begin
    ram_raddr = tab_index;
    if (state == S_RD1) begin
      ram_raddr = tab_index + TABLE_BITS'(1);
    end
  end

  lfo_am_ram #(
    .WIDTH (SINE_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_sine_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_addr),
    .wdata (sine_entry(fill_addr)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Datapath terms for the current step
  always_comb begin
    cur_sample  = is_right ? item.right_sample : item.left_sample;
    diff        = $signed({ram_rdata[SINE_BITS-1], ram_rdata}) - $signed({s0[SINE_BITS-1], s0});
    interp_prod = (SINE_BITS + FRAC_BITS + 1)'(d_mag)
                  * (SINE_BITS + FRAC_BITS + 1)'(ch_phase[FRAC_BITS-1:0]);
    s_val       = d_neg ? ($signed({{2{s0[SINE_BITS-1]}}, s0}) - $signed({1'b0, interp_t}))
                        : ($signed({{2{s0[SINE_BITS-1]}}, s0}) + $signed({1'b0, interp_t}));
    u_val       = s_val[SINE_BITS-1:0] + {1'b1, {(SINE_BITS-1){1'b0}}};
    acc         = {1'b0, smag, {PHASE_BITS{1'b0}}} - {1'b0, prod}
                  + (SAMPLE_BITS + PHASE_BITS + 1)'(64'd1 << (PHASE_BITS - 1));
    r_mag       = acc[PHASE_BITS +: SAMPLE_BITS];
    res         = sneg ? (~r_mag + SAMPLE_BITS'(1)) : r_mag;
    quot        = quot_prod[QPROD_BITS-1:QUOT_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b0;
      mono_step   <= MONO_STEP_RESET;
      stereo_step <= STEREO_STEP_RESET;
      depth       <= DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        REG_MONO_STEP:   mono_step   <= cfg_data[PHASE_BITS-1:0];
        REG_STEREO_STEP: stereo_step <= cfg_data[PHASE_BITS-1:0];
        REG_DEPTH:       depth       <= cfg_data[DEPTH_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_addr <= '0;
      phase     <= '0;
      is_right  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless the next one is loaded this cycle
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_FILL: begin
          fill_addr <= fill_addr + TABLE_BITS'(1);
          if (fill_addr == {TABLE_BITS{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            ch_phase <= phase;
            is_right <= 1'b0;
            phase    <= phase + (stereo_mode ? stereo_step : mono_step);
            state    <= S_RD0;
          end
        end
        S_RD0: begin
          sneg      <= cur_sample[SAMPLE_BITS-1];
          smag      <= cur_sample[SAMPLE_BITS-1] ? (~cur_sample + SAMPLE_BITS'(1))
                                                 : cur_sample;
          quot_prod <= QPROD_BITS'({1'b0, ch_phase[PHASE_BITS-1:1]}) * QPROD_BITS'(RECIP5);
          state     <= S_RD1;
        end
        S_RD1: begin
          s0          <= $signed(ram_rdata);
          // right phase is phase * 11 / 10, i.e. phase + phase / 10
          right_phase <= ch_phase + PHASE_BITS'(quot);
          state       <= S_DIFF;
        end
        S_DIFF: begin
          d_neg <= diff[SINE_BITS];
          d_mag <= diff[SINE_BITS] ? (~diff + (SINE_BITS + 1)'(1)) : diff;
          state <= S_INTERP;
        end
        S_INTERP: begin
          interp_t <= interp_prod[FRAC_BITS +: (SINE_BITS + 1)];
          state    <= S_GAIN;
        end
        S_GAIN: begin
          gain_p <= PHASE_BITS'(u_val) * PHASE_BITS'(depth);
          state  <= S_SMUL;
        end
        S_SMUL: begin
          prod  <= (SAMPLE_BITS + PHASE_BITS)'(smag) * (SAMPLE_BITS + PHASE_BITS)'(gain_p);
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (is_right) begin
            right_res <= res;
            state     <= S_OUT;
          end else begin
            left_res <= res;
            if (stereo_mode) begin
              is_right <= 1'b1;
              ch_phase <= right_phase;
              state    <= S_RD0;
            end else begin
              right_res <= '0;
              state     <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_data.left_out  <= left_res;
            out_data.right_out <= right_res;
            out_data.out_last  <= item.block_last;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_per_transaction: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice without processing");

  a_phase_moves_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(phase))
    else $error("phase moved without a transaction");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && !stereo_mode) |-> (out_data.right_out == '0))
    else $error("right output not zero in mono mode");
`endif

endmodule

`default_nettype wire
